[hdl/pdrs_pkg.sv]
// package: types, codes and constants of the periodic deadline request scheduler
package pdrs_pkg;

   localparam int MaxEntries = 16;
   localparam int SlotW = $clog2(MaxEntries);
   localparam int CountW = $clog2(MaxEntries + 1);

   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_ADD    = 3'd1,
      CMD_ENABLE = 3'd2,
      CMD_PAUSE  = 3'd3,
      CMD_NEXT   = 3'd4,
      CMD_DISP   = 3'd5,
      CMD_NOP    = 3'd6,
      CMD_BAD    = 3'd7
   } cmd_type;

   typedef enum logic [3:0] {
      ST_OK      = 4'd0,
      ST_INVALID = 4'd1,
      ST_FULL    = 4'd2,
      ST_DUP     = 4'd3,
      ST_NOTFND  = 4'd4,
      ST_READY   = 4'd5,
      ST_WAITING = 4'd6,
      ST_PAUSED  = 4'd7,
      ST_EMPTY   = 4'd8
   } status_type;

   localparam logic [0:0] CSR_PROTOCOL = 1'd0;
   localparam logic [0:0] CSR_MODULE   = 1'd1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FETCH,
      S_DISP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  key_protocol;
      logic [15:0] key_module;
      logic [31:0] key_id;
      logic [31:0] period_ms;
      logic [1:0]  priority_req;
      logic [63:0] time_ms;
      logic        flag;
      logic [3:0]  slot;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [3:0]  slot_out;
      logic [7:0]  out_protocol;
      logic [15:0] out_module;
      logic [31:0] out_id;
      logic [7:0]  short_id;
      logic        short_id_valid;
      logic [63:0] due_ms;
      logic [63:0] wait_ms;
   } rsp_type;

   // static part of an entry: written on add only
   typedef struct packed {
      logic [55:0] key;
      logic [31:0] interval;
      logic [1:0]  prio;
      logic [8:0]  short_id;
   } entry_type;

endpackage

[hdl/periodic_deadline_request_scheduler.sv]
// top level: periodic request table with earliest-deadline selection
// steps: clear, nop, pause, next while paused and a slot past the count finish without a
//   scan; mark dispatched reads its slot, then rewrites one due time; add, enable, next
//   and resume scan all n entries, max 16, before the result
// throughput: one request at a time, the next start is taken once busy falls (result cycle)
// reset: synchronous, clears state, count, pause, CSRs; entry memories are not cleared
module periodic_deadline_request_scheduler (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  pdrs_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output pdrs_pkg::rsp_type    rsp_data,
   input  logic                 csr_we,
   input  logic [0:0]           csr_index,
   input  logic [15:0]          csr_wdata
);
   import pdrs_pkg::*;

   // entry memories: static fields, due times, enable marks
   entry_type   ent_mem [MaxEntries];
   logic [63:0] due_mem [MaxEntries];
   logic        en_mem  [MaxEntries];

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [CountW-1:0] count_ff, count_in;
   logic        paused_ff, paused_in;
   logic [63:0] pstart_ff, pstart_in;
   logic [7:0]  cfg_prot_ff;
   logic [15:0] cfg_mod_ff;

   // scan pointers: read address issued and the entry whose data is back
   logic [CountW-1:0] rd_ptr_ff, rd_ptr_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [SlotW-1:0]  rd_idx_ff;
   entry_type         ent_q;
   logic [63:0]       due_q;
   logic              en_q;

   // scan accumulators
   logic        found_ff, found_in;     // key match
   logic [SlotW-1:0] fidx_ff, fidx_in;
   logic        have_en_ff, have_en_in;
   logic        due_hit_ff, due_hit_in;
   logic [63:0] earliest_ff, earliest_in;
   logic [SlotW-1:0] sel_ff, sel_in;
   logic [63:0] sel_due_ff, sel_due_in;
   logic [1:0]  sel_pri_ff, sel_pri_in;
   entry_type   sel_ent_ff, sel_ent_in;

   rsp_type     rsp_ff, rsp_in;
   logic        rspv_ff, rspv_in;

   // memory write ports
   logic              ent_we, due_we, en_we;
   logic [SlotW-1:0]  ent_wa, due_wa, en_wa;
   entry_type         ent_wd;
   logic [63:0]       due_wd;
   logic              en_wd;
   logic [SlotW-1:0]  rd_addr;

   logic [55:0] req_key;
   logic [63:0] span;
   logic [64:0] sum_a, sum_b;

   assign req_key = {req_ff.key_protocol, req_ff.key_module, req_ff.key_id};
   assign span = (req_ff.time_ms >= pstart_ff) ? req_ff.time_ms - pstart_ff : 64'd0;
   assign sum_a = {1'b0, due_q} + {33'd0, ent_q.interval};
   assign sum_b = {1'b0, req_ff.time_ms} + {33'd0, ent_q.interval};

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_wa] <= ent_wd;
      if (due_we) due_mem[due_wa] <= due_wd;
      if (en_we)  en_mem[en_wa]   <= en_wd;
      ent_q <= ent_mem[rd_addr];
      due_q <= due_mem[rd_addr];
      en_q  <= en_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         paused_ff   <= 1'b0;
         pstart_ff   <= '0;
         cfg_prot_ff <= '0;
         cfg_mod_ff  <= '0;
         rspv_ff     <= 1'b0;
         rd_vld_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         paused_ff <= paused_in;
         pstart_ff <= pstart_in;
         rspv_ff   <= rspv_in;
         rd_vld_ff <= rd_vld_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_PROTOCOL: cfg_prot_ff <= csr_wdata[7:0];
               CSR_MODULE:   cfg_mod_ff  <= csr_wdata;
               default:      cfg_mod_ff  <= cfg_mod_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == S_IDLE) req_ff <= req_data;
      rd_ptr_ff   <= rd_ptr_in;
      rd_idx_ff   <= rd_addr;
      found_ff    <= found_in;
      fidx_ff     <= fidx_in;
      have_en_ff  <= have_en_in;
      due_hit_ff  <= due_hit_in;
      earliest_ff <= earliest_in;
      sel_ff      <= sel_in;
      sel_due_ff  <= sel_due_in;
      sel_pri_ff  <= sel_pri_in;
      sel_ent_ff  <= sel_ent_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      logic [SlotW-1:0] cidx;
      logic [63:0]      add_sp;
      logic [64:0]      dsum;
      cidx = count_ff[SlotW-1:0];
      state_in    = state_ff;
      count_in    = count_ff;
      paused_in   = paused_ff;
      pstart_in   = pstart_ff;
      rd_ptr_in   = rd_ptr_ff;
      rd_vld_in   = 1'b0;
      rd_addr     = rd_ptr_ff[SlotW-1:0];
      found_in    = found_ff;
      fidx_in     = fidx_ff;
      have_en_in  = have_en_ff;
      due_hit_in  = due_hit_ff;
      earliest_in = earliest_ff;
      sel_in      = sel_ff;
      sel_due_in  = sel_due_ff;
      sel_pri_in  = sel_pri_ff;
      sel_ent_in  = sel_ent_ff;
      rsp_in      = '0;
      rspv_in     = 1'b0;
      ent_we = 1'b0; ent_wa = cidx; ent_wd = '0;
      due_we = 1'b0; due_wa = rd_idx_ff; due_wd = '0;
      en_we  = 1'b0; en_wa  = cidx; en_wd  = 1'b0;
      dsum = {1'b0, due_q} + {1'b0, span};
      add_sp = dsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dsum[63:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rd_ptr_in   = '0;
               found_in    = 1'b0;
               have_en_in  = 1'b0;
               due_hit_in  = 1'b0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            // commands without a scan end here; mark dispatched fetches its slot if in range
            unique case (cmd_type'(req_ff.cmd))
               CMD_CLEAR, CMD_NOP, CMD_BAD: state_in = S_DONE;
               CMD_PAUSE: if (req_ff.flag == 1'b1 || !paused_ff) state_in = S_DONE;
               CMD_NEXT:  if (paused_ff) state_in = S_DONE;
               CMD_DISP: begin
                  rd_addr  = req_ff.slot;
                  state_in = ({1'b0, req_ff.slot} >= count_ff) ? S_DONE : S_FETCH;
               end
               default: ;
            endcase
            if (state_in == S_SCAN) begin
               // issue read at rd_ptr, consume data from previous read
               if (rd_ptr_ff < count_ff) begin
                  rd_vld_in = 1'b1;
                  rd_ptr_in = rd_ptr_ff + 1'b1;
               end else if (!rd_vld_ff) begin
                  state_in = S_DONE;
               end
            end
            if (rd_vld_ff) begin
               if (ent_q.key == req_key && !found_ff) begin
                  found_in = 1'b1;
                  fidx_in  = rd_idx_ff;
               end
               if (req_ff.cmd == CMD_PAUSE) begin
                  due_we = 1'b1;
                  due_wd = add_sp;
               end
               if (req_ff.cmd == CMD_NEXT && en_q) begin
                  if (!have_en_ff || due_q < earliest_ff) earliest_in = due_q;
                  have_en_in = 1'b1;
                  if (due_q <= req_ff.time_ms) begin
                     if (!due_hit_ff || due_q < sel_due_ff ||
                         (due_q == sel_due_ff && ent_q.prio > sel_pri_ff)) begin
                        due_hit_in  = 1'b1;
                        sel_in      = rd_idx_ff;
                        sel_due_in  = due_q;
                        sel_pri_in  = ent_q.prio;
                        sel_ent_in  = ent_q;
                     end
                  end
               end
            end
         end
         S_FETCH: begin
            // keep reading the dispatched slot so its data is there in S_DISP
            rd_addr  = req_ff.slot;
            state_in = S_DISP;
         end
         S_DISP: begin
            rspv_in  = 1'b1;
            state_in = S_IDLE;
            rsp_in.status = ST_OK;
            if (sum_a[64]) begin
               rsp_in.status = ST_INVALID;
            end else if (sum_a[63:0] <= req_ff.time_ms) begin
               if (sum_b[64]) rsp_in.status = ST_INVALID;
               else begin
                  due_we = 1'b1; due_wa = req_ff.slot; due_wd = sum_b[63:0];
               end
            end else begin
               due_we = 1'b1; due_wa = req_ff.slot; due_wd = sum_a[63:0];
            end
         end
         S_DONE: begin
            rspv_in  = 1'b1;
            state_in = S_IDLE;
            rsp_in.status = ST_OK;
            unique case (cmd_type'(req_ff.cmd))
               CMD_CLEAR: begin
                  count_in = '0; paused_in = 1'b0; pstart_in = '0;
               end
               CMD_ADD: begin
                  if (req_ff.period_ms == 32'd0) rsp_in.status = ST_INVALID;
                  else if (found_ff) rsp_in.status = ST_DUP;
                  else if (count_ff >= CountW'(MaxEntries)) rsp_in.status = ST_FULL;
                  else begin
                     ent_we = 1'b1;
                     ent_wd.key = req_key;
                     ent_wd.interval = req_ff.period_ms;
                     ent_wd.prio = req_ff.priority_req;
                     ent_wd.short_id = (req_ff.key_protocol == cfg_prot_ff &&
                        req_ff.key_module == cfg_mod_ff && req_ff.key_id <= 32'd255) ?
                        {1'b1, req_ff.key_id[7:0]} : 9'd0;
                     due_we = 1'b1; due_wa = cidx; due_wd = req_ff.time_ms;
                     en_we  = 1'b1; en_wd = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               CMD_ENABLE: begin
                  if (!found_ff) rsp_in.status = ST_NOTFND;
                  else begin
                     en_we = 1'b1; en_wa = fidx_ff; en_wd = req_ff.flag;
                  end
               end
               CMD_PAUSE: begin
                  if (req_ff.flag && !paused_ff) begin
                     paused_in = 1'b1; pstart_in = req_ff.time_ms;
                  end else if (!req_ff.flag && paused_ff) begin
                     paused_in = 1'b0; pstart_in = '0;
                  end
               end
               CMD_NEXT: begin
                  if (paused_ff) rsp_in.status = ST_PAUSED;
                  else if (!have_en_ff) rsp_in.status = ST_EMPTY;
                  else if (!due_hit_ff) begin
                     rsp_in.status = ST_WAITING;
                     rsp_in.due_ms = earliest_ff;
                     rsp_in.wait_ms = (earliest_ff > req_ff.time_ms) ?
                        earliest_ff - req_ff.time_ms : 64'd0;
                  end else begin
                     rsp_in.status = ST_READY;
                     rsp_in.slot_out = sel_ff;
                     rsp_in.out_protocol = sel_ent_ff.key[55:48];
                     rsp_in.out_module = sel_ent_ff.key[47:32];
                     rsp_in.out_id = sel_ent_ff.key[31:0];
                     rsp_in.short_id = sel_ent_ff.short_id[7:0];
                     rsp_in.short_id_valid = sel_ent_ff.short_id[8];
                     rsp_in.due_ms = sel_due_ff;
                  end
               end
               CMD_DISP: rsp_in.status = ST_INVALID;  // slot past the count
               CMD_NOP: ;
               default: rsp_in.status = ST_INVALID;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // table count never exceeds the depth
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(MaxEntries)) else $error("count overflow");
   // a result follows only from a busy cycle
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without request");
   // a result is produced only while busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rspv_in |-> busy) else $error("result outside busy");
`endif

endmodule

[tb/periodic_deadline_request_scheduler_tb.sv]
// testbench: directed and random request streams checked against a behavioral schedule table
`timescale 1ns / 1ps

module periodic_deadline_request_scheduler_tb;
   import pdrs_pkg::*;

   localparam int HoldLimit   = 3000;  // cycles with no request, result or register write taken
   localparam int SettleWait  = 24;    // settle wait, longer than the longest request
   localparam logic [63:0] TopTime = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {OP_REQ, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct {
      op_kind_type kind;
      req_type     req;
      logic [0:0]  csr_idx;
      logic [15:0] csr_val;
      int          gap;
   } op_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [15:0] csr_wdata;

   op_type      pending_ops[$];
   rsp_type     expected_rsps[$];
   int          fail_count = 0;

   // behavioral copy of the schedule table
   int          tbl_count = 0;
   logic [55:0] tbl_key[MaxEntries];
   logic [31:0] tbl_interval[MaxEntries];
   logic [63:0] tbl_due[MaxEntries];
   logic [1:0]  tbl_prio[MaxEntries];
   logic        tbl_enabled[MaxEntries];
   logic [8:0]  tbl_short[MaxEntries];
   logic        tbl_paused = 1'b0;
   logic [63:0] tbl_pause_start = '0;
   logic [7:0]  reg_protocol = '0;
   logic [15:0] reg_module = '0;

   periodic_deadline_request_scheduler u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int find_entry(logic [55:0] key);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_key[i] == key) return i;
      return -1;
   endfunction

   // work out the response of one request and update the table
   function automatic rsp_type schedule_step(req_type r);
      rsp_type     o;
      logic [55:0] key;
      logic [63:0] span, iv, nd, earliest, now;
      int          f, sel;
      logic        have_en, due_hit, bad;
      o = '0;
      key = {r.key_protocol, r.key_module, r.key_id};
      now = r.time_ms;
      o.status = ST_OK;
      case (cmd_type'(r.cmd))
         CMD_CLEAR: begin
            tbl_count = 0;
            tbl_paused = 1'b0;
            tbl_pause_start = '0;
         end
         CMD_ADD: begin
            if (r.period_ms == 0) o.status = ST_INVALID;
            else if (find_entry(key) >= 0) o.status = ST_DUP;
            else if (tbl_count >= MaxEntries) o.status = ST_FULL;
            else begin
               tbl_key[tbl_count] = key;
               tbl_interval[tbl_count] = r.period_ms;
               tbl_due[tbl_count] = now;
               tbl_prio[tbl_count] = r.priority_req;
               tbl_enabled[tbl_count] = 1'b1;
               tbl_short[tbl_count] = (r.key_protocol == reg_protocol &&
                  r.key_module == reg_module && r.key_id <= 32'd255) ?
                  {1'b1, r.key_id[7:0]} : 9'd0;
               tbl_count++;
            end
         end
         CMD_ENABLE: begin
            f = find_entry(key);
            if (f < 0) o.status = ST_NOTFND;
            else tbl_enabled[f] = r.flag;
         end
         CMD_PAUSE: begin
            if (r.flag != tbl_paused) begin
               if (r.flag) begin
                  tbl_paused = 1'b1;
                  tbl_pause_start = now;
               end else begin
                  span = (now >= tbl_pause_start) ? now - tbl_pause_start : 64'd0;
                  for (int i = 0; i < tbl_count; i++)
                     tbl_due[i] = (tbl_due[i] > TopTime - span) ? TopTime : tbl_due[i] + span;
                  tbl_paused = 1'b0;
                  tbl_pause_start = '0;
               end
            end
         end
         CMD_NEXT: begin
            have_en = 1'b0;
            due_hit = 1'b0;
            sel = 0;
            earliest = TopTime;
            if (tbl_paused) o.status = ST_PAUSED;
            else begin
               for (int i = 0; i < tbl_count; i++) begin
                  if (!tbl_enabled[i]) continue;
                  if (!have_en || tbl_due[i] < earliest) earliest = tbl_due[i];
                  have_en = 1'b1;
                  if (tbl_due[i] > now) continue;
                  if (!due_hit || tbl_due[i] < tbl_due[sel] ||
                      (tbl_due[i] == tbl_due[sel] && tbl_prio[i] > tbl_prio[sel])) begin
                     sel = i;
                     due_hit = 1'b1;
                  end
               end
               if (!have_en) o.status = ST_EMPTY;
               else if (!due_hit) begin
                  o.status = ST_WAITING;
                  o.due_ms = earliest;
                  o.wait_ms = earliest - now;
               end else begin
                  o.status = ST_READY;
                  o.slot_out = sel[3:0];
                  {o.out_protocol, o.out_module, o.out_id} = tbl_key[sel];
                  o.short_id = tbl_short[sel][7:0];
                  o.short_id_valid = tbl_short[sel][8];
                  o.due_ms = tbl_due[sel];
               end
            end
         end
         CMD_DISP: begin
            if (r.slot >= tbl_count) o.status = ST_INVALID;
            else begin
               iv = {32'd0, tbl_interval[r.slot]};
               bad = tbl_due[r.slot] > TopTime - iv;
               nd = tbl_due[r.slot] + iv;
               if (!bad && nd <= now) begin
                  bad = now > TopTime - iv;
                  nd = now + iv;
               end
               if (bad) o.status = ST_INVALID;
               else tbl_due[r.slot] = nd;
            end
         end
         CMD_NOP: ;
         default: o.status = ST_INVALID;
      endcase
      return o;
   endfunction

   // driver: takes ops from the queue, holds start until the request is taken
   op_type      cur_op;
   logic        drv_active;
   int          gap_count;
   int          settle_count;
   logic        took_req;
   always @(posedge clock) begin
      logic        nx_start, nx_we, nx_took;
      req_type     nx_req;
      logic [0:0]  nx_idx;
      logic [15:0] nx_val;
      nx_req = req_data;
      nx_we = 1'b0;
      nx_idx = csr_index;
      nx_val = csr_wdata;
      nx_took = 1'b0;
      if (reset) begin
         drv_active = 1'b0;
         gap_count = -1;
         settle_count = 0;
         nx_req = '0;
         nx_idx = '0;
         nx_val = '0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(schedule_step(req_data));
            drv_active = 1'b0;
            nx_took = 1'b1;
         end
         if (!drv_active && pending_ops.size() > 0) begin
            cur_op = pending_ops[0];
            if (cur_op.kind == OP_REQ) begin
               if (gap_count < 0) gap_count = cur_op.gap;
               if (gap_count > 0) gap_count--;
               else begin
                  void'(pending_ops.pop_front());
                  nx_req = cur_op.req;
                  drv_active = 1'b1;
                  gap_count = -1;
               end
            end else if (expected_rsps.size() == 0 && !busy) begin
               // idle table: let any request in flight finish before touching registers
               if (settle_count < SettleWait) settle_count++;
               else begin
                  settle_count = 0;
                  void'(pending_ops.pop_front());
                  if (cur_op.kind == OP_CSR) begin
                     nx_we = 1'b1;
                     nx_idx = cur_op.csr_idx;
                     nx_val = cur_op.csr_val;
                     if (cur_op.csr_idx == CSR_PROTOCOL) reg_protocol = cur_op.csr_val[7:0];
                     else reg_module = cur_op.csr_val;
                  end
               end
            end else settle_count = 0;
         end
      end
      nx_start = drv_active;
      took_req <= nx_took;
      start <= nx_start;
      req_data <= nx_req;
      csr_we <= nx_we;
      csr_index <= nx_idx;
      csr_wdata <= nx_val;
   end

   // monitor: every strobed response is matched against the oldest prediction
   logic took_rsp;
   always @(posedge clock) begin
      rsp_type e;
      logic    nx_seen;
      nx_seen = 1'b0;
      if (!reset && rsp_valid) begin
         nx_seen = 1'b1;
         if (expected_rsps.size() == 0) begin
            $error("response with no request outstanding: status %0d", rsp_data.status);
            fail_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.slot_out !== e.slot_out) begin
               $error("slot_out expected %0d actual %0d", e.slot_out, rsp_data.slot_out);
               fail_count++;
            end
            if (rsp_data.out_protocol !== e.out_protocol) begin
               $error("out_protocol expected %0h actual %0h", e.out_protocol,
                      rsp_data.out_protocol);
               fail_count++;
            end
            if (rsp_data.out_module !== e.out_module) begin
               $error("out_module expected %0h actual %0h", e.out_module, rsp_data.out_module);
               fail_count++;
            end
            if (rsp_data.out_id !== e.out_id) begin
               $error("out_id expected %0h actual %0h", e.out_id, rsp_data.out_id);
               fail_count++;
            end
            if (rsp_data.short_id !== e.short_id) begin
               $error("short_id expected %0h actual %0h", e.short_id, rsp_data.short_id);
               fail_count++;
            end
            if (rsp_data.short_id_valid !== e.short_id_valid) begin
               $error("short_id_valid expected %0b actual %0b", e.short_id_valid,
                      rsp_data.short_id_valid);
               fail_count++;
            end
            if (rsp_data.due_ms !== e.due_ms) begin
               $error("due_ms expected %0h actual %0h", e.due_ms, rsp_data.due_ms);
               fail_count++;
            end
            if (rsp_data.wait_ms !== e.wait_ms) begin
               $error("wait_ms expected %0h actual %0h", e.wait_ms, rsp_data.wait_ms);
               fail_count++;
            end
         end
      end
      took_rsp <= nx_seen;
   end

   // watchdog: nothing moving for too long means the block is hung
   int idle_cycles;
   always @(posedge clock) begin
      if (reset || took_req || took_rsp || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HoldLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   // stimulus
   logic [55:0] key_pool[24];
   logic [63:0] now_ms;
   logic        burst_mode;

   function automatic req_type noise_req();
      req_type r;
      r.cmd = 3'($urandom);
      r.key_protocol = 8'($urandom);
      r.key_module = 16'($urandom);
      r.key_id = $urandom;
      r.period_ms = $urandom;
      r.priority_req = 2'($urandom);
      r.time_ms = {$urandom, $urandom};
      r.flag = 1'($urandom);
      r.slot = 4'($urandom);
      return r;
   endfunction

   function automatic void push_req(req_type r);
      op_type op;
      op.kind = OP_REQ;
      op.req = r;
      op.csr_idx = '0;
      op.csr_val = '0;
      if (burst_mode) op.gap = 0;
      else op.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      pending_ops.push_back(op);
   endfunction

   function automatic void push_cmd(cmd_type c, logic [55:0] key, logic [31:0] iv,
                                    logic [1:0] pr, logic [63:0] t, logic fl, logic [3:0] sl);
      req_type r;
      r = noise_req();
      r.cmd = c;
      {r.key_protocol, r.key_module, r.key_id} = key;
      r.period_ms = iv;
      r.priority_req = pr;
      r.time_ms = t;
      r.flag = fl;
      r.slot = sl;
      push_req(r);
   endfunction

   function automatic void push_csr(logic [0:0] idx, logic [15:0] val);
      op_type op;
      op.kind = OP_CSR;
      op.csr_idx = idx;
      op.csr_val = val;
      op.gap = 0;
      pending_ops.push_back(op);
   endfunction

   function automatic void push_drain();
      op_type op;
      op.kind = OP_DRAIN;
      op.gap = 0;
      pending_ops.push_back(op);
   endfunction

   // keys land on the configured standard codes often, so short ids show up
   function automatic void refill_keys(logic [7:0] p, logic [15:0] m);
      for (int i = 0; i < 24; i++)
         key_pool[i] = {($urandom_range(0, 1) ? p : 8'($urandom)),
                        ($urandom_range(0, 1) ? m : 16'($urandom)),
                        ($urandom_range(0, 1) ? 32'($urandom_range(0, 300)) : $urandom)};
   endfunction

   function automatic logic [31:0] pick_interval();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return $urandom;
         2: return 32'hFFFF_FFFF;
         default: return 32'($urandom_range(1, 1000));
      endcase
   endfunction

   function automatic void random_phase(int n, logic [7:0] p, logic [15:0] m,
                                        logic [63:0] base);
      int k;
      refill_keys(p, m);
      now_ms = base;
      push_cmd(CMD_CLEAR, '0, 0, 0, now_ms, 0, 0);
      for (int i = 0; i < n; i++) begin
         if (i % 60 == 0) burst_mode = $urandom_range(0, 2) == 0;
         now_ms = now_ms + 64'($urandom_range(0, 400));
         k = $urandom_range(0, 99);
         if (k < 5) push_req(noise_req());
         else if (k < 8) push_cmd(CMD_CLEAR, '0, 0, 0, now_ms, 0, 0);
         else if (k < 33)
            push_cmd(CMD_ADD, key_pool[$urandom_range(0, 23)], pick_interval(),
                     2'($urandom), now_ms + 64'($urandom_range(0, 600)) - 64'd300,
                     1'($urandom), 4'($urandom));
         else if (k < 43)
            push_cmd(CMD_ENABLE, key_pool[$urandom_range(0, 23)], $urandom, 2'($urandom),
                     now_ms, $urandom_range(0, 2) != 0, 4'($urandom));
         else if (k < 50)
            push_cmd(CMD_PAUSE, '0, $urandom, 2'($urandom),
                     now_ms - 64'($urandom_range(0, 20)), 1'($urandom), 4'($urandom));
         else if (k < 78)
            push_cmd(CMD_NEXT, '0, $urandom, 2'($urandom), now_ms, 1'($urandom),
                     4'($urandom));
         else if (k < 97)
            push_cmd(CMD_DISP, '0, $urandom, 2'($urandom), now_ms, 1'($urandom),
                     4'($urandom_range(0, 15)));
         else push_cmd(CMD_NOP, '0, $urandom, 2'($urandom), now_ms, 1'($urandom),
                       4'($urandom));
         if (i == n / 2) push_drain();
      end
   endfunction

   initial begin
      logic [55:0] std_key;
      burst_mode = 1'b0;

      // directed part: codes at their extremes, every command and corner
      push_csr(CSR_PROTOCOL, 16'h00FF);
      push_csr(CSR_MODULE, 16'hFFFF);
      std_key = {8'hFF, 16'hFFFF, 32'd255};
      push_cmd(CMD_NEXT, '0, 0, 0, 64'd0, 0, 0);
      push_cmd(CMD_ADD, std_key, 32'd0, 2'd3, 64'd10, 1, 0);
      push_cmd(CMD_ADD, std_key, 32'hFFFF_FFFF, 2'd0, TopTime - 64'd5, 1, 0);
      push_cmd(CMD_ADD, {8'hFF, 16'hFFFF, 32'd256}, 32'd7, 2'd3, 64'd100, 0, 0);
      push_cmd(CMD_ADD, std_key, 32'd9, 2'd1, 64'd3, 0, 0);
      push_cmd(CMD_ADD, {8'h00, 16'h0000, 32'hFFFF_FFFF}, 32'd50, 2'd2, 64'd100, 0, 0);
      push_cmd(CMD_NEXT, '0, 0, 0, 64'd99, 0, 0);
      push_cmd(CMD_NEXT, '0, 0, 0, 64'd100, 0, 0);
      push_cmd(CMD_DISP, '0, 0, 0, 64'd100, 0, 4'd0);
      push_cmd(CMD_DISP, '0, 0, 0, 64'd5000, 0, 4'd1);
      push_cmd(CMD_DISP, '0, 0, 0, TopTime, 0, 4'd2);
      push_cmd(CMD_DISP, '0, 0, 0, 64'd0, 0, 4'd15);
      push_cmd(CMD_ENABLE, {8'h12, 16'h3456, 32'd1}, 0, 0, 0, 0, 0);
      push_cmd(CMD_ENABLE, {8'h00, 16'h0000, 32'hFFFF_FFFF}, 0, 0, 0, 0, 0);
      push_cmd(CMD_PAUSE, '0, 0, 0, 64'd1000, 1, 0);
      push_cmd(CMD_PAUSE, '0, 0, 0, 64'd2000, 1, 0);
      push_cmd(CMD_NEXT, '0, 0, 0, 64'd1000, 0, 0);
      push_cmd(CMD_PAUSE, '0, 0, 0, TopTime, 0, 0);
      push_cmd(CMD_PAUSE, '0, 0, 0, 64'd10, 1, 0);
      push_cmd(CMD_PAUSE, '0, 0, 0, 64'd5, 0, 0);
      push_cmd(CMD_NEXT, '0, 0, 0, TopTime, 0, 0);
      push_cmd(CMD_BAD, '0, 0, 0, 0, 0, 0);
      push_cmd(CMD_NOP, '0, 0, 0, 0, 0, 0);
      push_drain();
      // fill the table past its size; the extra add reports full
      push_cmd(CMD_CLEAR, '0, 0, 0, 0, 0, 0);
      for (int i = 0; i < MaxEntries + 1; i++)
         push_cmd(CMD_ADD, {8'h00, 16'h0000, 32'(i)}, 32'd10, 2'($urandom), 64'd20, 0, 0);
      push_cmd(CMD_NEXT, '0, 0, 0, 64'd20, 0, 0);

      // random phases, each under a different pair of register values
      random_phase(250, 8'hFF, 16'hFFFF, 64'd0);
      push_csr(CSR_PROTOCOL, 16'h0000);
      push_csr(CSR_MODULE, 16'h0000);
      random_phase(250, 8'h00, 16'h0000, 64'd1000);
      push_csr(CSR_PROTOCOL, 16'h0033);
      push_csr(CSR_MODULE, 16'h7E12);
      random_phase(250, 8'h33, 16'h7E12, TopTime - 64'd60000);
      push_csr(CSR_PROTOCOL, 16'h00A5);
      push_csr(CSR_MODULE, 16'h8001);
      random_phase(250, 8'hA5, 16'h8001, {$urandom, $urandom} >> 1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_ops.size() > 0 || drv_active || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (SettleWait) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
